### rtl/core/assert_macros.svh
// Assertion macros shared by the push-out resolver RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk_s, rst_s, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) !(cond)) else $error(msg);

`endif

### rtl/core/apor_pkg.sv
// Shared types and constants for the box push-out resolver.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package apor_pkg;

  // Command codes carried in the mode field.
  localparam logic [1:0] MODE_WRITE   = 2'd0;
  localparam logic [1:0] MODE_RESOLVE = 2'd1;
  localparam logic [1:0] MODE_READ    = 2'd2;

  localparam logic [3:0]  CNT_MAX = 4'd15;

  // One input transaction.
  typedef struct packed {
    logic [1:0]         mode;
    logic [3:0]         slot;
    logic signed [31:0] in_x;
    logic signed [31:0] in_y;
    logic signed [31:0] in_z;
    logic [30:0]        in_half_x;
    logic [30:0]        in_half_y;
    logic [30:0]        in_half_z;
    logic               in_trigger;
    logic               in_static;
    logic               in_present;
  } in_item_t;

  // One result transaction.
  typedef struct packed {
    logic signed [31:0] res_x;
    logic signed [31:0] res_y;
    logic signed [31:0] res_z;
    logic [3:0]         contacts;
  } res_item_t;

  // One slot of the box table.
  typedef struct packed {
    logic [31:0] ctr_x;
    logic [31:0] ctr_y;
    logic [31:0] ctr_z;
    logic [30:0] ext_x;
    logic [30:0] ext_y;
    logic [30:0] ext_z;
    logic        trig;
    logic        stat;
    logic        pres;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;         // capture the incoming transaction
    logic wr_item;      // write the captured transaction into its slot
    logic rd_slot;      // read the table at the command slot
    logic rd_walk;      // read the table at the walk index
    logic latch_mover;  // keep the mover's extents and static flag
    logic eval;         // compute overlaps against the entry just read
    logic apply;        // apply the push-out for the evaluated entry
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] mode;
    logic       ok;     // command slot lies inside the table
    logic       skip;   // entry just read takes no part in the resolve
  } sts_t;

endpackage

`default_nettype wire

### rtl/core/apor_table.sv
// Box table: one write port, one registered read port, per-slot valid bits.
// Depends on apor_pkg for the entry type and on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module apor_table #(
  parameter int SLOTS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(SLOTS)-1:0] wr_addr,
  input  wire apor_pkg::entry_t         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(SLOTS)-1:0] rd_addr,
  output apor_pkg::entry_t              rd_data
);

  apor_pkg::entry_t mem [SLOTS];
  logic [SLOTS-1:0] valid;
  apor_pkg::entry_t rd_raw;
  logic             rd_v;

  // Storage array and its registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_raw <= mem[rd_addr];
    end
  end

  // Valid bits: a slot never written reads as all zeros.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rd_v  <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_v <= valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_v ? rd_raw : '0;

  // The walk never reads the slot that is being written back.
  `ASSERT_NEVER(a_rw_same_slot, clk, rst, wr_en && rd_en && (wr_addr == rd_addr), "table read and write hit the same slot")

endmodule

`default_nettype wire

### rtl/core/apor_datapath.sv
// Datapath of the resolver: captured command, running mover center, overlap
// and push-out arithmetic, and the box table. Depends on apor_pkg and apor_table.
`default_nettype none

module apor_datapath #(
  parameter int SLOTS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire apor_pkg::cmd_t           cmd,
  input  wire logic [$clog2(SLOTS)-1:0] idx,
  input  wire apor_pkg::in_item_t       request,
  output apor_pkg::sts_t                sts,
  output apor_pkg::res_item_t           result
);

  localparam int IW = $clog2(SLOTS);

  apor_pkg::in_item_t req_q;
  apor_pkg::entry_t   item_entry;
  apor_pkg::entry_t   rd_data;
  apor_pkg::entry_t   oth;
  apor_pkg::entry_t   oth_upd;
  apor_pkg::entry_t   wr_data;
  logic [IW-1:0]      slot_addr;
  logic [IW-1:0]      rd_addr;
  logic [IW-1:0]      rd_idx_q;
  logic [IW-1:0]      oth_idx;
  logic [IW-1:0]      wr_addr;
  logic               wr_en;
  logic               rd_en;
  logic               ok;

  logic [30:0] mov_hx, mov_hy, mov_hz;
  logic        mov_stat;
  logic [31:0] rx, ry, rz;
  logic [3:0]  cnt;

  logic [32:0] dx, dy, dz;
  logic [33:0] ox, oy, oz;
  logic        sx, sy, sz;

  logic        contact;
  logic        ax_x, ax_y, ax_z;
  logic [33:0] push;
  logic [33:0] half;
  logic [33:0] dmov, doth;
  logic [31:0] rx_new, ry_new, rz_new;

  // Signed difference of two centers, 33 bits.
  function automatic logic [32:0] cdiff(input logic [31:0] a, input logic [31:0] b);
    return {a[31], a} - {b[31], b};
  endfunction

  // Sum of half extents minus the absolute center difference, 34-bit signed.
  function automatic logic [33:0] overlap(input logic [32:0] d, input logic [30:0] ha,
                                          input logic [30:0] hb);
    logic [32:0] a;
    a = d[32] ? (33'd0 - d) : d;
    return {3'b000, ha} + {3'b000, hb} - {1'b0, a};
  endfunction

  // Clamp a 35-bit signed value into 32 bits.
  function automatic logic [31:0] sat32(input logic [34:0] v);
    logic [31:0] r;
    if (v[34:31] == 4'b0000 || v[34:31] == 4'b1111) begin
      r = v[31:0];
    end else if (v[34]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7fff_ffff;
    end
    return r;
  endfunction

  // Center plus a 34-bit signed offset, saturated.
  function automatic logic [31:0] add_sat(input logic [31:0] c, input logic [33:0] d);
    return sat32({{3{c[31]}}, c} + {d[33], d});
  endfunction

  // Center minus a 34-bit signed offset, saturated.
  function automatic logic [31:0] sub_sat(input logic [31:0] c, input logic [33:0] d);
    return sat32({{3{c[31]}}, c} - {d[33], d});
  endfunction

  // Command decode.
  assign ok        = (32'(req_q.slot) < SLOTS);
  assign slot_addr = IW'(req_q.slot);

  assign item_entry = '{ctr_x: req_q.in_x, ctr_y: req_q.in_y, ctr_z: req_q.in_z,
                         ext_x: req_q.in_half_x, ext_y: req_q.in_half_y,
                         ext_z: req_q.in_half_z, trig: req_q.in_trigger,
                         stat: req_q.in_static, pres: req_q.in_present};

  // Table ports: a command write or a write-back of the pushed box.
  assign rd_en   = cmd.rd_slot || cmd.rd_walk;
  assign rd_addr = cmd.rd_slot ? slot_addr : idx;
  assign wr_en   = (cmd.wr_item && ok) || (cmd.apply && contact);
  assign wr_addr = cmd.wr_item ? slot_addr : oth_idx;
  assign wr_data = cmd.wr_item ? item_entry : oth_upd;

  apor_table #(
    .SLOTS (SLOTS)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Status back to the controller.
  assign sts.mode = req_q.mode;
  assign sts.ok   = ok;
  assign sts.skip = (rd_idx_q == slot_addr) || rd_data.trig || !rd_data.pres;

  // Overlap of the running mover box with the entry just read.
  assign dx = cdiff(rx, rd_data.ctr_x);
  assign dy = cdiff(ry, rd_data.ctr_y);
  assign dz = cdiff(rz, rd_data.ctr_z);

  // Push-out for the evaluated entry: least overlap, ties to x then y.
  assign contact = ($signed(ox) > 0) && ($signed(oy) > 0) && ($signed(oz) > 0);
  assign ax_x    = ($signed(ox) <= $signed(oy)) && ($signed(ox) <= $signed(oz));
  assign ax_y    = !ax_x && ($signed(oy) <= $signed(ox)) && ($signed(oy) <= $signed(oz));
  assign ax_z    = !ax_x && !ax_y;

  always_comb begin
    priority if (ax_x) begin
      push = sx ? ox : (34'd0 - ox);
    end else if (ax_y) begin
      push = sy ? oy : (34'd0 - oy);
    end else begin
      push = sz ? oz : (34'd0 - oz);
    end
  end

  assign half = {push[33], push[33:1]};

  // Split of the push-out between mover and other box by their static flags.
  always_comb begin
    unique case ({mov_stat, oth.stat})
      2'b11: begin
        dmov = '0;
        doth = '0;
      end
      2'b01: begin
        dmov = push;
        doth = '0;
      end
      2'b10: begin
        dmov = '0;
        doth = push;
      end
      default: begin
        dmov = half;
        doth = half;
      end
    endcase
  end

  assign rx_new = ax_x ? add_sat(rx, dmov) : rx;
  assign ry_new = ax_y ? add_sat(ry, dmov) : ry;
  assign rz_new = ax_z ? add_sat(rz, dmov) : rz;

  always_comb begin
    oth_upd = oth;
    if (ax_x) begin
      oth_upd.ctr_x = sub_sat(oth.ctr_x, doth);
    end
    if (ax_y) begin
      oth_upd.ctr_y = sub_sat(oth.ctr_y, doth);
    end
    if (ax_z) begin
      oth_upd.ctr_z = sub_sat(oth.ctr_z, doth);
    end
  end

  // Captured command and per-walk registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= request;
    end
    if (rd_en) begin
      rd_idx_q <= rd_addr;
    end
    if (cmd.latch_mover) begin
      mov_hx   <= rd_data.ext_x;
      mov_hy   <= rd_data.ext_y;
      mov_hz   <= rd_data.ext_z;
      mov_stat <= rd_data.stat;
    end
    if (cmd.eval) begin
      ox      <= overlap(dx, mov_hx, rd_data.ext_x);
      oy      <= overlap(dy, mov_hy, rd_data.ext_y);
      oz      <= overlap(dz, mov_hz, rd_data.ext_z);
      sx      <= !dx[32];
      sy      <= !dy[32];
      sz      <= !dz[32];
      oth     <= rd_data;
      oth_idx <= rd_idx_q;
    end
  end

  // Running mover center and contact count.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rx  <= request.in_x;
      ry  <= request.in_y;
      rz  <= request.in_z;
      cnt <= '0;
    end else if (cmd.apply && contact) begin
      rx  <= rx_new;
      ry  <= ry_new;
      rz  <= rz_new;
      if (cnt != apor_pkg::CNT_MAX) begin
        cnt <= cnt + 4'd1;
      end
    end
  end

  // Result selection by command.
  always_comb begin
    result = '0;
    unique case (req_q.mode)
      apor_pkg::MODE_RESOLVE: begin
        result.res_x    = rx;
        result.res_y    = ry;
        result.res_z    = rz;
        result.contacts = cnt;
      end
      apor_pkg::MODE_READ: begin
        if (ok) begin
          result.res_x = rd_data.ctr_x;
          result.res_y = rd_data.ctr_y;
          result.res_z = rd_data.ctr_z;
        end
      end
      default: begin
        result = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/apor_ctrl.sv
// Controller of the resolver: command sequencing and the walk over the table.
// Depends on apor_pkg for command and status types and on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module apor_ctrl #(
  parameter int SLOTS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire apor_pkg::sts_t           sts,
  output logic                          busy,
  output logic                          done,
  output apor_pkg::cmd_t                cmd,
  output logic [$clog2(SLOTS)-1:0]      idx_addr
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_RDW  = 3'd2;
  localparam logic [2:0] S_MOV  = 3'd3;
  localparam logic [2:0] S_OVL  = 3'd4;
  localparam logic [2:0] S_UPD  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]    state, state_next;
  logic [CW-1:0] idx, idx_next;
  logic          last;

  // All slots have been read once the walk index reaches the table depth.
  assign last     = (idx == CW'(SLOTS));
  assign idx_addr = idx[IW-1:0];

  // Next-state and command decode.
  always_comb begin
    cmd        = '0;
    state_next = state;
    idx_next   = idx;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        idx_next = '0;
        unique case (sts.mode)
          apor_pkg::MODE_WRITE: begin
            cmd.wr_item = 1'b1;
            state_next  = S_DONE;
          end
          apor_pkg::MODE_READ: begin
            cmd.rd_slot = 1'b1;
            state_next  = S_RDW;
          end
          apor_pkg::MODE_RESOLVE: begin
            if (sts.ok) begin
              cmd.rd_slot = 1'b1;
              state_next  = S_MOV;
            end else begin
              state_next = S_DONE;
            end
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_RDW: begin
        state_next = S_DONE;
      end
      S_MOV: begin
        cmd.latch_mover = 1'b1;
        cmd.rd_walk     = 1'b1;
        idx_next        = idx + CW'(1);
        state_next      = S_OVL;
      end
      S_OVL: begin
        cmd.eval = 1'b1;
        if (!sts.skip) begin
          state_next = S_UPD;
        end else if (last) begin
          state_next = S_DONE;
        end else begin
          cmd.rd_walk = 1'b1;
          idx_next    = idx + CW'(1);
        end
      end
      S_UPD: begin
        cmd.apply = 1'b1;
        if (last) begin
          state_next = S_DONE;
        end else begin
          cmd.rd_walk = 1'b1;
          idx_next    = idx + CW'(1);
          state_next  = S_OVL;
        end
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and walk index registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  // A result strobe lasts one cycle and an accepted command raises busy.
  `ASSERT_ALWAYS(a_done_single, clk, rst, done |=> !done, "result strobe held for more than one cycle")
  `ASSERT_ALWAYS(a_accept_busy, clk, rst, start && !busy |=> busy, "accepted command did not raise busy")

endmodule

`default_nettype wire

### rtl/core/aabb_push_out_resolver.sv
// Box push-out resolver, top level: controller plus datapath with the box table.
// Depends on apor_pkg, apor_ctrl and apor_datapath.
//
// A transaction is taken when start is high and busy is low; busy then stays
// high until the result has been shown. The single result sits on the result
// port for exactly one cycle with done high; the receiver cannot stall it and
// must take it in that cycle. A write goes from decode straight to done; a
// read first passes the read state. A resolve reads the mover's slot and then
// walks the table through its one read port, one slot per cycle for skipped
// slots; an evaluated slot also takes the update state before the walk goes
// on, because each slot's overlap test depends on the mover center left by
// the slot before. The mover's own slot is always skipped. A resolve whose
// slot lies beyond the table goes from decode straight to done, as a write
// does. A new command is accepted in the cycle after done.
`default_nettype none

module aabb_push_out_resolver #(
  parameter int SLOTS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire apor_pkg::in_item_t  request,
  output logic                     busy,
  output logic                     done,
  output apor_pkg::res_item_t      result
);

  apor_pkg::cmd_t             cmd;
  apor_pkg::sts_t             sts;
  logic [$clog2(SLOTS)-1:0]   idx_addr;

  // Command sequencing.
  apor_ctrl #(
    .SLOTS (SLOTS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .sts      (sts),
    .busy     (busy),
    .done     (done),
    .cmd      (cmd),
    .idx_addr (idx_addr)
  );

  // Arithmetic and storage.
  apor_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .idx     (idx_addr),
    .request (request),
    .sts     (sts),
    .result  (result)
  );

endmodule

`default_nettype wire
